// ===== src/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pkg
// Types and constants shared by the SD SPI sector host files.
// ----------------------------------------------------------------------------
`default_nettype none
package ssh_pkg;

    // sector size in bytes; the buffer address width follows from it
    localparam int SECTOR_BYTES = 512;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_CMD_PRE, PH_CMD_BYTE, PH_CMD_SKIP, PH_CMD_POLL,
        PH_YIELD, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY,
        PH_RTOKEN, PH_RDATA, PH_RCRC, PH_CLOSE
    } t_phase;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_READ  = 3'd1,
        MODE_WRITE = 3'd2,
        MODE_LOAD  = 3'd3,
        MODE_CARD  = 3'd4
    } t_mode;

    localparam logic [1:0] KIND_XCHG = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CMD0_TO = 3'd1;
    localparam logic [2:0] ST_INIT_TO = 3'd2;
    localparam logic [2:0] ST_WR_ERR  = 3'd3;
    localparam logic [2:0] ST_RD_ERR  = 3'd4;

    localparam logic [7:0] CMD0   = 8'h40;
    localparam logic [7:0] CMD1   = 8'h41;
    localparam logic [7:0] CMD55  = 8'h77;
    localparam logic [7:0] ACMD41 = 8'h69;
    localparam logic [7:0] CMD24  = 8'h58;
    localparam logic [7:0] CMD17  = 8'h51;
    localparam logic [7:0] CRC0   = 8'h95;
    localparam logic [7:0] TOKEN  = 8'hfe;
    localparam logic [7:0] IDLE_B = 8'hff;
    localparam logic [7:0] RESP_M = 8'h1f;
    localparam logic [7:0] RESP_OK = 8'h05;

endpackage
`default_nettype wire

// ===== src/sd_spi_sector_host.sv =====
// ----------------------------------------------------------------------------
// sd_spi_sector_host
// SD/MMC SPI-mode host sequencer with a buffered write sector.
// ----------------------------------------------------------------------------
// Each accepted item gives at most two results, which go into a two-entry
// output queue; input ready is high whenever the queue has room for two,
// so items flow back to back while the consumer keeps up. The write sector
// sits in a RAM with registered read data: the byte for the next exchange
// is read ahead (address = next byte count) so it is ready when the card
// byte arrives. Because loads can land on that entry, a load to the address
// just fetched is forwarded into the prefetched byte.
// Init sends wake bytes deselected, then CMD0, CMD55 with ACMD41 or CMD1;
// read/write send CMD17/CMD24 with sector times sector size. A start item
// aborts any running operation. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module sd_spi_sector_host #(
    parameter int YIELD_BYTES  = 100,
    parameter int WAKE_BYTES   = 15
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_mode,
    input  wire  [22:0] i_sector,
    input  wire  [8:0]  i_byte_index,
    input  wire  [7:0]  i_data_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_chip_select,
    output logic        o_fast_clock,
    output logic [7:0]  o_read_byte,
    output logic [8:0]  o_read_index,
    output logic [2:0]  o_status,
    output logic        o_card_is_sd,
    output logic        o_last
);
    import ssh_pkg::*;

    localparam int AW = $clog2(SECTOR_BYTES);
    localparam int RES_W = 2 + 8 + 1 + 1 + 8 + 9 + 3 + 1 + 1;

    // ---- state ----
    logic [7:0]  r_retry;
    t_phase      r_phase, n_phase;
    logic [22:0] r_sector, n_sector;
    logic [12:0] r_count, n_count;
    logic [7:0]  r_outer, n_outer;
    logic [7:0]  r_poll, n_poll;
    logic [7:0]  r_cmd, n_cmd;
    logic        r_sd, n_sd;
    logic        r_init, n_init;
    logic [2:0]  r_dstat, n_dstat;

    // ---- sector buffer ----
    logic          ram_we;
    logic [AW-1:0] ram_raddr, r_raddr;
    logic [7:0]    ram_rdata, buf_byte;
    logic          r_fwd;
    logic [7:0]    r_fwd_data;

    // ---- output queue ----
    logic [RES_W-1:0] r_q [2];
    logic [1:0]       r_qn;

    logic acc;
    logic [7:0] lim;
    logic [31:0] addr32;
    logic [7:0] rb;

    // results of this item
    logic        e0, e1;
    logic [RES_W-1:0] p0, p1;

    assign acc = i_valid && o_ready;
    assign o_ready = (r_qn == 2'd0) || (r_qn == 2'd1 && i_ready);
    assign lim = (r_retry == 8'd0) ? 8'd1 : r_retry;
    assign addr32 = {9'd0, r_sector} << AW;
    assign rb = i_data_byte;

    assign ram_we = acc && i_mode == MODE_LOAD && 32'(i_byte_index) < 32'(SECTOR_BYTES);

    always_comb begin
        buf_byte = r_fwd ? r_fwd_data : ram_rdata;
    end

    ssh_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_byte_index[AW-1:0]),
        .i_wdata(i_data_byte),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    function automatic logic [RES_W-1:0] pack(input logic [1:0] k, input logic [7:0] tx,
                                              input logic cs, input logic fc,
                                              input logic [7:0] rd, input logic [8:0] ri,
                                              input logic [2:0] st, input logic sd);
        return {k, tx, cs, fc, rd, ri, st, sd, 1'b0};
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [7:0] code, input logic [2:0] k,
                                            input logic [31:0] a);
        logic rw;
        rw = (code == CMD17) || (code == CMD24);
        case (k)
            3'd0: return code;
            3'd1: return rw ? a[31:24] : 8'd0;
            3'd2: return rw ? a[23:16] : 8'd0;
            3'd3: return rw ? a[15:8] : 8'd0;
            3'd4: return rw ? a[7:0] : 8'd0;
            default: return (code == CMD0) ? CRC0 : IDLE_B;
        endcase
    endfunction

    always_comb begin
        logic       x;
        logic [7:0] xtx;
        logic       xcs;
        logic [7:0] cc;
        logic       fin;
        logic [2:0] fst;
        logic       bc;
        logic [7:0] bcode;
        logic [7:0] o1;
        n_phase = r_phase; n_sector = r_sector; n_count = r_count; n_outer = r_outer;
        n_poll = r_poll; n_cmd = r_cmd; n_sd = r_sd; n_init = r_init; n_dstat = r_dstat;
        x = 1'b0; xtx = IDLE_B; xcs = 1'b0; fin = 1'b0; fst = ST_OK;
        bc = 1'b0; bcode = 8'd0; cc = 8'd0; o1 = 8'd0;
        e0 = 1'b0; p0 = '0;
        if (acc) begin
            case (i_mode)
                MODE_INIT: begin
                    n_init = 1'b0; n_count = '0; n_outer = '0; n_phase = PH_WAKE;
                    x = 1'b1; xcs = 1'b1;
                end
                MODE_READ, MODE_WRITE: begin
                    n_sector = i_sector; n_outer = '0; bc = 1'b1;
                    bcode = (i_mode == MODE_READ) ? CMD17 : CMD24;
                end
                MODE_CARD: begin
                    case (r_phase)
                        PH_WAKE: begin
                            n_count = r_count + 13'd1;
                            if (32'(n_count) < 32'(WAKE_BYTES)) begin
                                x = 1'b1; xcs = 1'b1;
                            end else begin
                                n_outer = '0; bc = 1'b1; bcode = CMD0;
                            end
                        end
                        PH_CMD_PRE: begin
                            n_phase = PH_CMD_BYTE; n_count = '0; x = 1'b1;
                            xtx = cmd_byte(r_cmd, 3'd0, addr32);
                        end
                        PH_CMD_BYTE: begin
                            n_count = r_count + 13'd1; x = 1'b1;
                            if (n_count < 13'd6) begin
                                xtx = cmd_byte(r_cmd, n_count[2:0], addr32);
                            end else begin
                                n_phase = PH_CMD_SKIP;
                            end
                        end
                        PH_CMD_SKIP: begin
                            n_phase = PH_CMD_POLL; n_poll = '0; x = 1'b1;
                        end
                        PH_CMD_POLL: begin
                            n_poll = r_poll + 8'd1;
                            if (rb == IDLE_B && n_poll < lim) begin
                                x = 1'b1;
                            end else begin
                                case (r_cmd)
                                    CMD0: begin
                                        o1 = r_outer + 8'd1; n_outer = o1;
                                        if (rb == 8'd1) begin
                                            n_outer = '0; bc = 1'b1; bcode = CMD55;
                                        end else if (o1 < lim) begin
                                            bc = 1'b1; bcode = CMD0;
                                        end else begin
                                            fin = 1'b1; fst = ST_CMD0_TO;
                                        end
                                    end
                                    CMD55: begin
                                        bc = 1'b1; bcode = (rb == 8'd1) ? ACMD41 : CMD1;
                                    end
                                    ACMD41, CMD1: begin
                                        if (rb == 8'd0) begin
                                            n_sd = (r_cmd == ACMD41); n_init = 1'b1;
                                            fin = 1'b1;
                                        end else begin
                                            o1 = r_outer + 8'd1; n_outer = o1;
                                            if (o1 < lim) begin
                                                bc = 1'b1; bcode = CMD55;
                                            end else begin
                                                fin = 1'b1; fst = ST_INIT_TO;
                                            end
                                        end
                                    end
                                    CMD17, CMD24: begin
                                        o1 = r_outer + 8'd1; n_outer = o1;
                                        if (rb == 8'd0) begin
                                            x = 1'b1;
                                            if (r_cmd == CMD17) begin
                                                n_phase = PH_RTOKEN;
                                            end else begin
                                                n_count = '0;
                                                if (YIELD_BYTES > 0) begin
                                                    n_phase = PH_YIELD;
                                                end else begin
                                                    n_phase = PH_WTOKEN; xtx = TOKEN;
                                                end
                                            end
                                        end else if (o1 < lim) begin
                                            bc = 1'b1; bcode = r_cmd;
                                        end else begin
                                            fin = 1'b1;
                                            fst = (r_cmd == CMD17) ? ST_RD_ERR : ST_WR_ERR;
                                        end
                                    end
                                    default: fin = 1'b1;
                                endcase
                            end
                        end
                        PH_YIELD: begin
                            n_count = r_count + 13'd1; x = 1'b1;
                            if (32'(n_count) >= 32'(YIELD_BYTES)) begin
                                n_phase = PH_WTOKEN; xtx = TOKEN;
                            end
                        end
                        PH_WTOKEN: begin
                            n_phase = PH_WDATA; n_count = '0; x = 1'b1; xtx = buf_byte;
                        end
                        PH_WDATA: begin
                            n_count = r_count + 13'd1; x = 1'b1;
                            if (32'(n_count) < 32'(SECTOR_BYTES)) begin
                                xtx = buf_byte;
                            end else begin
                                n_phase = PH_WCRC; n_count = '0;
                            end
                        end
                        PH_WCRC: begin
                            n_count = r_count + 13'd1; x = 1'b1;
                            if (n_count >= 13'd2) n_phase = PH_WRESP;
                        end
                        PH_WRESP: begin
                            if ((rb & RESP_M) != RESP_OK) begin
                                fin = 1'b1; fst = ST_WR_ERR;
                            end else begin
                                n_phase = PH_WBUSY; x = 1'b1;
                            end
                        end
                        PH_WBUSY: begin
                            if (rb == IDLE_B) fin = 1'b1;
                            else x = 1'b1;
                        end
                        PH_RTOKEN: begin
                            if (rb == TOKEN) begin
                                n_phase = PH_RDATA; n_count = '0;
                            end
                            x = 1'b1;
                        end
                        PH_RDATA: begin
                            e0 = 1'b1;
                            p0 = pack(KIND_DATA, 8'd0, 1'b0, r_init, rb, 9'(r_count),
                                      ST_OK, r_sd);
                            n_count = r_count + 13'd1;
                            if (32'(n_count) >= 32'(SECTOR_BYTES)) begin
                                n_phase = PH_RCRC; n_count = '0;
                            end
                            x = 1'b1;
                        end
                        PH_RCRC: begin
                            n_count = r_count + 13'd1;
                            if (n_count < 13'd2) x = 1'b1;
                            else fin = 1'b1;
                        end
                        PH_CLOSE: begin
                            e0 = 1'b1;
                            p0 = pack(KIND_DONE, 8'd0, 1'b0, r_init, 8'd0, 9'd0,
                                      r_dstat, r_sd);
                            n_phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (bc) begin
            n_cmd = bcode; n_count = '0; n_phase = PH_CMD_PRE; x = 1'b1; xcs = 1'b1;
            xtx = IDLE_B;
        end
        if (fin) begin
            n_dstat = fst; n_phase = PH_CLOSE; x = 1'b1; xcs = 1'b1; xtx = IDLE_B;
        end
        cc = xtx;
        e1 = x;
        p1 = pack(KIND_XCHG, cc, xcs, n_init, 8'd0, 9'd0, ST_OK, n_sd);
        // prefetch the buffer byte that the next write data exchange needs
        ram_raddr = r_raddr;
        if (acc) ram_raddr = (n_phase == PH_WDATA && 32'(n_count) + 1 < 32'(SECTOR_BYTES))
                             ? AW'(n_count + 13'd1) : AW'(0);
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= ram_raddr;
        r_fwd <= ram_we && i_byte_index[AW-1:0] == ram_raddr;
        r_fwd_data <= i_data_byte;
        if (!i_rst_n) begin
            r_retry <= 8'd200;
            r_phase <= PH_IDLE; r_sector <= '0; r_count <= '0; r_outer <= '0;
            r_poll <= '0; r_cmd <= '0; r_sd <= 1'b0; r_init <= 1'b0; r_dstat <= ST_OK;
            r_qn <= 2'd0;
        end else begin
            if (i_cfg_we) r_retry <= i_cfg_data;
            r_phase <= n_phase; r_sector <= n_sector; r_count <= n_count;
            r_outer <= n_outer; r_poll <= n_poll; r_cmd <= n_cmd; r_sd <= n_sd;
            r_init <= n_init; r_dstat <= n_dstat;
            begin
                logic [1:0] qn;
                logic [RES_W-1:0] q0, q1;
                logic [RES_W-1:0] a0, a1;
                logic [1:0] na;
                qn = r_qn; q0 = r_q[0]; q1 = r_q[1];
                if (o_valid && i_ready) begin
                    q0 = q1; qn = qn - 2'd1;
                end
                na = {1'b0, e0} + {1'b0, e1};
                a0 = e0 ? p0 : p1;
                a1 = p1;
                if (na == 2'd1) a0[0] = 1'b1;
                if (na == 2'd2) a1[0] = 1'b1;
                if (na != 2'd0) begin
                    if (qn == 2'd0) begin
                        q0 = a0; q1 = a1;
                    end else begin
                        q1 = a0;
                    end
                end
                r_q[0] <= q0; r_q[1] <= q1; r_qn <= qn + na;
            end
        end
    end

    assign o_valid = r_qn != 2'd0;
    assign {o_kind, o_tx_byte, o_chip_select, o_fast_clock, o_read_byte, o_read_index,
            o_status, o_card_is_sd, o_last} = r_q[0];
endmodule
`default_nettype wire

// ===== src/ssh_ram.sv =====
// ----------------------------------------------------------------------------
// ssh_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ssh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== verif/tb_sd_spi_sector_host.sv =====
// ----------------------------------------------------------------------------
// tb_sd_spi_sector_host
// Self-checking bench for the SD SPI-mode sector host. The bench plays the
// card: every card byte it sends is chosen from the predicted sequencer phase,
// so init, read and write sequences run end to end, with timeouts, aborts and
// noise mixed in. Each result item is checked field by field against an
// in-bench model of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_sd_spi_sector_host;
    import ssh_pkg::*;

    localparam int YIELD_BYTES  = 100;
    localparam int WAKE_BYTES   = 15;
    localparam int MOOD_GOOD    = 0;   // card answers as a healthy card mostly would
    localparam int MOOD_BAD     = 1;   // card never gives the answer that moves on
    localparam int MOOD_STUCK   = 2;   // card leaves idle state but never gets ready

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_mode = 3'd0;
    logic [22:0] i_sector = 23'd0;
    logic [8:0]  i_byte_index = 9'd0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_chip_select;
    logic        o_fast_clock;
    logic [7:0]  o_read_byte;
    logic [8:0]  o_read_index;
    logic [2:0]  o_status;
    logic        o_card_is_sd;
    logic        o_last;

    sd_spi_sector_host dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_sector(i_sector), .i_byte_index(i_byte_index),
        .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_tx_byte(o_tx_byte), .o_chip_select(o_chip_select),
        .o_fast_clock(o_fast_clock), .o_read_byte(o_read_byte),
        .o_read_index(o_read_index), .o_status(o_status),
        .o_card_is_sd(o_card_is_sd), .o_last(o_last)
    );

    always #1 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx;
        logic       cs;
        logic       fast;
        logic [7:0] rb;
        logic [8:0] ri;
        logic [2:0] st;
        logic       sd;
        logic       last;
    } t_host_result;

    t_host_result host_results_q[$];

    // Sequencer model state
    t_phase      seq_phase;
    logic [7:0]  seq_limit;
    logic [22:0] seq_sector;
    logic [7:0]  seq_buf [SECTOR_BYTES];
    int          seq_count;
    logic [7:0]  seq_outer;
    logic [7:0]  seq_poll;
    logic [7:0]  seq_cmd;
    logic        seq_sd;
    logic        seq_init;
    logic [2:0]  seq_done_st;

    t_host_result step_res [2];
    int           step_n;

    int idle_pct  = 0;
    int stall_pct = 0;
    int card_mood = MOOD_GOOD;
    int n_items   = 0;
    int n_results = 0;
    int n_errors  = 0;
    int n_done    = 0;
    int n_reads   = 0;
    int n_writes  = 0;
    int n_inits   = 0;

    // ------------------------------------------------------------------
    // Model of the sequencer
    // ------------------------------------------------------------------
    function automatic logic [7:0] eff_limit();
        return (seq_limit == 8'd0) ? 8'd1 : seq_limit;
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] tx, logic cs,
                                 logic [7:0] rb, logic [8:0] ri, logic [2:0] st);
        t_host_result r;
        if (step_n >= 2) return;
        r.kind = k; r.tx = tx; r.cs = cs; r.fast = seq_init; r.rb = rb;
        r.ri = ri; r.st = st; r.sd = seq_sd; r.last = 1'b0;
        step_res[step_n] = r;
        step_n++;
    endfunction

    function automatic void xchg(logic [7:0] tx, logic cs);
        emit(KIND_XCHG, tx, cs, 8'd0, 9'd0, ST_OK);
    endfunction

    function automatic logic [7:0] frame_byte(int k);
        logic [31:0] addr;
        logic        rw;
        addr = {seq_sector, 9'd0};
        rw = (seq_cmd == CMD17) || (seq_cmd == CMD24);
        case (k)
            0: return seq_cmd;
            1: return rw ? addr[31:24] : 8'd0;
            2: return rw ? addr[23:16] : 8'd0;
            3: return rw ? addr[15:8] : 8'd0;
            4: return rw ? addr[7:0] : 8'd0;
            default: return (seq_cmd == CMD0) ? CRC0 : IDLE_B;
        endcase
    endfunction

    function automatic void start_cmd(logic [7:0] code);
        seq_cmd = code;
        seq_count = 0;
        seq_phase = PH_CMD_PRE;
        xchg(IDLE_B, 1'b1);
    endfunction

    function automatic void close_op(logic [2:0] st);
        seq_done_st = st;
        seq_phase = PH_CLOSE;
        xchg(IDLE_B, 1'b1);
    endfunction

    function automatic void retry_or_close(logic [7:0] code, logic [2:0] st);
        if (seq_outer < eff_limit()) start_cmd(code);
        else close_op(st);
    endfunction

    function automatic void judge_reply(logic [7:0] r);
        case (seq_cmd)
            CMD0: begin
                seq_outer++;
                if (r == 8'd1) begin
                    seq_outer = 0;
                    start_cmd(CMD55);
                end else begin
                    retry_or_close(CMD0, ST_CMD0_TO);
                end
            end
            CMD55: start_cmd(r == 8'd1 ? ACMD41 : CMD1);
            ACMD41, CMD1: begin
                if (r == 8'd0) begin
                    seq_sd = (seq_cmd == ACMD41);
                    seq_init = 1'b1;
                    close_op(ST_OK);
                end else begin
                    seq_outer++;
                    retry_or_close(CMD55, ST_INIT_TO);
                end
            end
            CMD17: begin
                seq_outer++;
                if (r == 8'd0) begin
                    seq_phase = PH_RTOKEN;
                    xchg(IDLE_B, 1'b0);
                end else begin
                    retry_or_close(CMD17, ST_RD_ERR);
                end
            end
            CMD24: begin
                seq_outer++;
                if (r == 8'd0) begin
                    seq_count = 0;
                    seq_phase = PH_YIELD;
                    xchg(IDLE_B, 1'b0);
                end else begin
                    retry_or_close(CMD24, ST_WR_ERR);
                end
            end
            default: close_op(ST_OK);
        endcase
    endfunction

    function automatic void take_card_byte(logic [7:0] r);
        case (seq_phase)
            PH_WAKE: begin
                seq_count++;
                if (seq_count < WAKE_BYTES) begin
                    xchg(IDLE_B, 1'b1);
                end else begin
                    seq_outer = 0;
                    start_cmd(CMD0);
                end
            end
            PH_CMD_PRE: begin
                seq_phase = PH_CMD_BYTE;
                seq_count = 0;
                xchg(frame_byte(0), 1'b0);
            end
            PH_CMD_BYTE: begin
                seq_count++;
                if (seq_count < 6) begin
                    xchg(frame_byte(seq_count), 1'b0);
                end else begin
                    seq_phase = PH_CMD_SKIP;
                    xchg(IDLE_B, 1'b0);
                end
            end
            PH_CMD_SKIP: begin
                seq_phase = PH_CMD_POLL;
                seq_poll = 0;
                xchg(IDLE_B, 1'b0);
            end
            PH_CMD_POLL: begin
                seq_poll++;
                if (r == IDLE_B && seq_poll < eff_limit()) xchg(IDLE_B, 1'b0);
                else judge_reply(r);
            end
            PH_YIELD: begin
                seq_count++;
                if (seq_count < YIELD_BYTES) begin
                    xchg(IDLE_B, 1'b0);
                end else begin
                    seq_phase = PH_WTOKEN;
                    xchg(TOKEN, 1'b0);
                end
            end
            PH_WTOKEN: begin
                seq_phase = PH_WDATA;
                seq_count = 0;
                xchg(seq_buf[0], 1'b0);
            end
            PH_WDATA: begin
                seq_count++;
                if (seq_count < SECTOR_BYTES) begin
                    xchg(seq_buf[seq_count], 1'b0);
                end else begin
                    seq_phase = PH_WCRC;
                    seq_count = 0;
                    xchg(IDLE_B, 1'b0);
                end
            end
            PH_WCRC: begin
                seq_count++;
                if (seq_count >= 2) seq_phase = PH_WRESP;
                xchg(IDLE_B, 1'b0);
            end
            PH_WRESP: begin
                if ((r & RESP_M) != RESP_OK) begin
                    close_op(ST_WR_ERR);
                end else begin
                    seq_phase = PH_WBUSY;
                    xchg(IDLE_B, 1'b0);
                end
            end
            PH_WBUSY: begin
                if (r == IDLE_B) close_op(ST_OK);
                else xchg(IDLE_B, 1'b0);
            end
            PH_RTOKEN: begin
                if (r == TOKEN) begin
                    seq_phase = PH_RDATA;
                    seq_count = 0;
                end
                xchg(IDLE_B, 1'b0);
            end
            PH_RDATA: begin
                emit(KIND_DATA, 8'd0, 1'b0, r, seq_count[8:0], ST_OK);
                seq_count++;
                if (seq_count >= SECTOR_BYTES) begin
                    seq_phase = PH_RCRC;
                    seq_count = 0;
                end
                xchg(IDLE_B, 1'b0);
            end
            PH_RCRC: begin
                seq_count++;
                if (seq_count < 2) xchg(IDLE_B, 1'b0);
                else close_op(ST_OK);
            end
            PH_CLOSE: begin
                emit(KIND_DONE, 8'd0, 1'b0, 8'd0, 9'd0, seq_done_st);
                seq_phase = PH_IDLE;
            end
            default: ;
        endcase
    endfunction

    // Work out the results of one accepted item and queue them
    function automatic void predict_item(logic [2:0] mode, logic [22:0] sec,
                                         logic [8:0] idx, logic [7:0] db);
        step_n = 0;
        case (mode)
            MODE_INIT: begin
                seq_init = 1'b0;
                seq_count = 0;
                seq_outer = 0;
                seq_phase = PH_WAKE;
                xchg(IDLE_B, 1'b1);
            end
            MODE_READ, MODE_WRITE: begin
                seq_sector = sec;
                seq_outer = 0;
                start_cmd(mode == MODE_READ ? CMD17 : CMD24);
            end
            MODE_LOAD: seq_buf[idx] = db;
            MODE_CARD: if (seq_phase != PH_IDLE) take_card_byte(db);
            default: ;
        endcase
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int k = 0; k < step_n; k++) host_results_q.push_back(step_res[k]);
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    task automatic send_item(logic [2:0] mode, logic [22:0] sec, logic [8:0] idx,
                             logic [7:0] db);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_sector <= sec;
        i_byte_index <= idx;
        i_data_byte <= db;
        do @(posedge i_clk); while (!o_ready);
        predict_item(mode, sec, idx, db);
        n_items++;
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (host_results_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_retry_limit(logic [7:0] v);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seq_limit = v;
    endtask

    task automatic set_pressure(int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
    endtask

    // Pick the card's answer from the phase the host is in
    function automatic logic [7:0] card_answer();
        logic [7:0] rnd;
        logic       good;
        logic       wakes;
        rnd = 8'($urandom);
        good = (card_mood == MOOD_GOOD) && ($urandom_range(99) < 80);
        wakes = (card_mood != MOOD_BAD) && ($urandom_range(99) < 80);
        case (seq_phase)
            PH_CMD_POLL: begin
                if ($urandom_range(99) < 15) return IDLE_B;
                case (seq_cmd)
                    CMD0: return wakes ? 8'd1 : (rnd == 8'd1 ? 8'd4 : rnd);
                    CMD55: return (card_mood == MOOD_BAD || $urandom_range(1)) ? 8'd1 : rnd;
                    default: return good ? 8'd0 : (rnd == 8'd0 ? 8'd1 : rnd);
                endcase
            end
            PH_RTOKEN: return ($urandom_range(99) < 40) ? TOKEN : rnd;
            PH_WRESP: return good ? {rnd[7:5], RESP_OK[4:0]} : rnd;
            PH_WBUSY: return ($urandom_range(99) < 30) ? IDLE_B : rnd;
            default: return rnd;
        endcase
    endfunction

    task automatic card_byte();
        send_item(MODE_CARD, 23'($urandom), 9'($urandom), card_answer());
    endtask

    // Start one operation and play the card until it has closed. Abort and
    // noise are in tenths of a percent per card byte.
    task automatic run_op(logic [2:0] mode, logic [22:0] sec, int abort_pm, int noise_pm);
        send_item(mode, sec, 9'($urandom), 8'($urandom));
        while (seq_phase != PH_IDLE) begin
            if ($urandom_range(999) < abort_pm)
                send_item(3'($urandom_range(MODE_WRITE)), 23'($urandom), 9'($urandom),
                          8'($urandom));
            else if ($urandom_range(999) < noise_pm)
                send_item(($urandom_range(1) ? MODE_LOAD : 3'($urandom_range(7, 5))),
                          23'($urandom), 9'($urandom), 8'($urandom));
            else
                card_byte();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_host_result e;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (host_results_q.size() == 0) begin
                $error("unexpected result: kind %0d tx %02h", o_kind, o_tx_byte);
                n_errors++;
            end else begin
                e = host_results_q.pop_front();
                if (o_kind == KIND_DONE) n_done++;
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_kind); n_errors++;
                end
                if (o_tx_byte !== e.tx) begin
                    $error("tx_byte: expected %02h, got %02h", e.tx, o_tx_byte); n_errors++;
                end
                if (o_chip_select !== e.cs) begin
                    $error("chip_select: expected %0d, got %0d", e.cs, o_chip_select);
                    n_errors++;
                end
                if (o_fast_clock !== e.fast) begin
                    $error("fast_clock: expected %0d, got %0d", e.fast, o_fast_clock);
                    n_errors++;
                end
                if (o_read_byte !== e.rb) begin
                    $error("read_byte: expected %02h, got %02h", e.rb, o_read_byte);
                    n_errors++;
                end
                if (o_read_index !== e.ri) begin
                    $error("read_index: expected %0d, got %0d", e.ri, o_read_index);
                    n_errors++;
                end
                if (o_status !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, o_status); n_errors++;
                end
                if (o_card_is_sd !== e.sd) begin
                    $error("card_is_sd: expected %0d, got %0d", e.sd, o_card_is_sd);
                    n_errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last); n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_init();
        // idle card bytes and unused modes give nothing
        send_item(MODE_CARD, 23'h7fffff, 9'h1ff, 8'hff);
        send_item(3'd5, 23'd0, 9'd0, 8'd0);
        send_item(3'd7, 23'h7fffff, 9'h1ff, 8'hff);
        set_pressure(78, 0);
        run_op(MODE_INIT, 23'h7fffff, 0, 0);
        n_inits++;
    endtask

    task automatic test_read();
        set_pressure(0, 78);
        run_op(MODE_READ, 23'h7fffff, 0, 5);
        n_reads++;
    endtask

    task automatic test_timeouts();
        set_pressure(0, 0);
        card_mood = MOOD_BAD;
        set_retry_limit(8'd1);
        run_op(MODE_INIT, 23'd0, 0, 0);                 // CMD0 timeout
        n_inits++;
        set_retry_limit(8'd0);                          // zero acts as one
        run_op(MODE_READ, 23'h155555, 0, 0);
        run_op(MODE_WRITE, 23'h0f0f0f, 0, 0);
        n_reads++;
        n_writes++;
        // CMD0 answered, ACMD41 or CMD1 never ready
        set_retry_limit(8'd3);
        card_mood = MOOD_STUCK;
        while (1) begin
            run_op(MODE_INIT, 23'd0, 0, 0);
            n_inits++;
            if (seq_done_st == ST_INIT_TO) break;
        end
        card_mood = MOOD_GOOD;
    endtask

    // Write part of a sector with loads landing on the entries being sent,
    // then abort it mid-sector with a read that the card refuses
    task automatic test_write();
        set_pressure(29, 29);
        card_mood = MOOD_GOOD;
        for (int k = 0; k < 32; k++)
            send_item(MODE_LOAD, 23'($urandom), 9'(k), 8'($urandom));
        send_item(MODE_WRITE, 23'h2aaaaa, 9'($urandom), 8'($urandom));
        while (seq_phase != PH_IDLE && !(seq_phase == PH_WDATA && seq_count >= 24)) begin
            if ($urandom_range(99) < 4)
                send_item(MODE_LOAD, 23'($urandom), 9'($urandom_range(31)), 8'($urandom));
            else
                card_byte();
        end
        n_writes++;
        card_mood = MOOD_BAD;
        run_op(MODE_READ, 23'h000abc, 0, 0);
        n_reads++;
        card_mood = MOOD_GOOD;
    endtask

    initial begin
        seq_phase = PH_IDLE;
        seq_limit = 8'd200;
        seq_sector = '0;
        seq_count = 0;
        seq_outer = '0;
        seq_poll = '0;
        seq_cmd = '0;
        seq_sd = 1'b0;
        seq_init = 1'b0;
        seq_done_st = ST_OK;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_init();
        test_read();
        test_timeouts();
        test_write();
        wait_quiet();

        $display("Covered %0d items and %0d results: %0d inits, %0d reads, %0d writes,",
                 n_items, n_results, n_inits, n_reads, n_writes);
        $display("%0d operations closed, with command timeouts, a zero retry limit and an aborted write.",
                 n_done);
        if (n_errors == 0 && host_results_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
